FILE: rtl/core/kth_smallest_sorted_matrix_core_assert.svh
// Assertion macros for the sorted-matrix selection core.
`ifndef KTH_SMALLEST_SORTED_MATRIX_CORE_ASSERT_SVH
`define KTH_SMALLEST_SORTED_MATRIX_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property at every clock outside reset.
`define KSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition implies another in the next cycle.
`define KSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KSM_ASSERT(lbl, prop, msg)
`define KSM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/ksm_pkg.sv
// Types, constants and helper functions of the sorted-matrix selection core.
package ksm_pkg;

  // Configuration
  localparam int MAX_N_DEF = 64;
  localparam int SIZE_W    = 7;
  localparam int RANK_W    = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANK        = 1'b1;

  // Pivot generator (64-bit Mersenne Twister)
  localparam int GEN_W      = 64;
  localparam int MT_N       = 312;
  localparam int MT_M       = 156;
  localparam int GEN_AW     = 9;
  localparam int DIV_CNT_W  = 6;
  localparam logic [63:0] GEN_SEED   = 64'd1337;
  localparam logic [63:0] SEED_MULT  = 64'h5851_F42D_4C95_7F2D;
  localparam logic [63:0] TWIST_MAG  = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] UPPER_MASK = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] LOWER_MASK = 64'h0000_0000_7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] element_value;
    logic               last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] selected_value;
    logic               found;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_ROW_INIT,
    S_SEED_FIRST,
    S_SEED_M0,
    S_SEED_M1,
    S_SEED_M2,
    S_SEED_WR,
    S_ACT_RD,
    S_ACT_ACC,
    S_GEN_CHK,
    S_TW_PRIME,
    S_TW_LOAD,
    S_TW_RD,
    S_TW_WR,
    S_GEN_RD,
    S_GEN_TEMPER,
    S_DIV,
    S_FIND_RD,
    S_FIND_CHK,
    S_PIV_RD,
    S_PIV_GET,
    S_WALK_RD,
    S_WALK_ROW,
    S_CELL_RD,
    S_CELL_CHK,
    S_WALK_END,
    S_DECIDE,
    S_UPD_RD,
    S_UPD_WR,
    S_ITER_NEXT,
    S_RESULT
  } state_t;

  // Output tempering of one generator word
  function automatic logic [63:0] gen_temper(input logic [63:0] w);
    logic [63:0] x;
    x = w;
    x = x ^ ((x >> 29) & 64'h5555_5555_5555_5555);
    x = x ^ ((x << 17) & 64'h71D6_7FFF_EDA6_0000);
    x = x ^ ((x << 37) & 64'hFFF7_EEE0_0000_0000);
    x = x ^ (x >> 43);
    return x;
  endfunction

endpackage

FILE: rtl/core/ksm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ksm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/kth_smallest_sorted_matrix_core.sv
// Top level: loads a sorted matrix and selects its rank-th smallest value.
//
//   port group | dir | handshake       | beat payload
//   in_        | in  | in_valid/ready  | in_item_t  (element_value, last_element)
//   out_       | out | out_valid/ready | out_item_t (selected_value, found)
//   cfg_       | in  | cfg_we only     | cfg_index, cfg_wdata (matrix_size, rank)
//
// Loading accepts one element beat per cycle while idle; the element goes to the matrix RAM.
// A last_element beat starts a selection that runs for a data-dependent time:
// about n rows of init, generator seeding, then per pivot an active sum,
// a modulo, a pick, one or two staircase walks with their matrix RAM reads
// and a bound update, plus a generator refill once per 312 pivots. The single
// read port of the matrix RAM paces the walks.
// Reset clears control only; no RAM clearing pass. The input stalls during a
// selection; a finished result waits in the output register for out_ready.
`include "kth_smallest_sorted_matrix_core_assert.svh"
module kth_smallest_sorted_matrix_core #(
  parameter int MAX_N = ksm_pkg::MAX_N_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ksm_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ksm_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [ksm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ksm_pkg::CFG_DW-1:0]          cfg_wdata
);

  import ksm_pkg::*;

  localparam int STORE_DEPTH = MAX_N * MAX_N;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int RW          = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int NW          = $clog2(MAX_N + 1);
  localparam int CW          = $clog2(MAX_N) + 2;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1) + 1;
  localparam int CMP_W       = (CNT_W > RANK_W) ? CNT_W : RANK_W;
  localparam int ROW_DW      = 3 * CW;

  // Registers
  state_t                     state_r, state_nxt;
  logic [SIZE_W-1:0]          size_r, size_nxt;
  logic [RANK_W-1:0]          rank_r, rank_nxt;
  logic [STORE_AW-1:0]        load_pos_r, load_pos_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_item_t                  out_item_r, out_item_nxt;
  logic [NW-1:0]              cur_n_r, cur_n_nxt;
  logic [RW-1:0]              row_idx_r, row_idx_nxt;
  logic [STORE_AW-1:0]        row_base_r, row_base_nxt;
  logic [CNT_W-1:0]           disc_r, disc_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [CNT_W-1:0]           base_r, base_nxt;
  logic [CNT_W-1:0]           pick_r, pick_nxt;
  logic [STORE_AW-1:0]        iter_r, iter_nxt;
  logic [GEN_AW-1:0]          gen_idx_r, gen_idx_nxt;
  logic [GEN_AW-1:0]          gi_r, gi_nxt;
  logic [63:0]                seed_p_r, seed_p_nxt;
  logic [63:0]                prod_r, prod_nxt;
  logic [31:0]                hi_r, hi_nxt;
  logic [63:0]                tw_cur_r, tw_cur_nxt;
  logic [63:0]                div_x_r, div_x_nxt;
  logic [DIV_CNT_W-1:0]       div_cnt_r, div_cnt_nxt;
  logic signed [CW-1:0]       wc_r, wc_nxt;
  logic signed [CW-1:0]       wl_r, wl_nxt;
  logic signed [CW-1:0]       wr_r, wr_nxt;
  logic                       strict_r, strict_nxt;
  logic                       upd_right_r, upd_right_nxt;
  logic signed [31:0]         pivot_r, pivot_nxt;
  logic                       found_r, found_nxt;

  // Memory ports
  logic                       st_we;
  logic [STORE_AW-1:0]        st_raddr;
  logic [31:0]                st_rdata;
  logic                       row_we;
  logic [RW-1:0]              row_waddr;
  logic [ROW_DW-1:0]          row_wdata;
  logic [ROW_DW-1:0]          row_rdata;
  logic                       gen_we;
  logic [GEN_AW-1:0]          gen_waddr;
  logic [63:0]                gen_wdata;
  logic [GEN_AW-1:0]          gen_raddr_a, gen_raddr_b;
  logic [63:0]                gen_rdata_a, gen_rdata_b;

  // Shared datapath terms
  logic                       in_acc;
  logic                       out_free;
  logic                       last_row;
  logic [2*NW-1:0]            nn_w;
  logic                       rank_bad;
  logic signed [CW-1:0]       row_l, row_r, row_c;
  logic signed [CW-1:0]       n_m1;
  logic [CNT_W-1:0]           row_w;
  logic [CNT_W-1:0]           act_sum;
  logic                       find_hit;
  logic signed [CW-1:0]       c_min;
  logic signed [CW-1:0]       wc_dec;
  logic signed [31:0]         cell_v;
  logic                       cell_gt;
  logic [CNT_W-1:0]           walk_add;
  logic [CNT_W-1:0]           tot;
  logic [CNT_W:0]             div_t;
  logic [CNT_W:0]             div_rem;
  logic [63:0]                seed_q;
  logic [31:0]                mul_a, mul_b;
  logic [63:0]                mul_p;
  logic [63:0]                tw_y;
  logic [63:0]                tw_v;
  logic [GEN_AW-1:0]          gi_p1, gi_pm;
  logic signed [CW-1:0]       span;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign out_free  = !out_valid_r || out_ready;

  assign last_row  = (row_idx_r == RW'(cur_n_r - NW'(1)));
  assign nn_w      = cur_n_r * cur_n_r;
  assign rank_bad  = (rank_r == '0) || (32'(rank_r) > 32'(nn_w));

  assign row_l = row_rdata[3*CW-1:2*CW];
  assign row_r = row_rdata[2*CW-1:CW];
  assign row_c = row_rdata[CW-1:0];
  assign n_m1  = CW'(cur_n_r) - CW'(1);

  // Active width of the row just read
  assign row_w    = (row_l <= row_r) ? CNT_W'($unsigned(row_r - row_l + CW'(1))) : '0;
  assign act_sum  = cnt_r + row_w;
  assign find_hit = (pick_r < (base_r + row_w));

  // Staircase walk terms
  assign c_min    = (wc_r > row_r) ? row_r : wc_r;
  assign wc_dec   = wc_r - CW'(1);
  assign cell_v   = st_rdata;
  assign cell_gt  = strict_r ? (cell_v >= pivot_r) : (cell_v > pivot_r);
  assign span     = wc_r - wl_r + CW'(1);
  assign walk_add = (wc_r >= wl_r) ? CNT_W'($unsigned(span)) : '0;
  assign tot      = disc_r + cnt_r;

  // Restoring modulo step: one quotient bit per cycle
  assign div_t   = {pick_r, div_x_r[63]};
  assign div_rem = (div_t >= {1'b0, cnt_r}) ? (div_t - {1'b0, cnt_r}) : div_t;

  // Seeding multiplier, shared over the states S_SEED_M0, S_SEED_M1 and S_SEED_M2
  assign seed_q = seed_p_r ^ (seed_p_r >> 62);
  always_comb begin
    mul_a = seed_q[31:0];
    mul_b = SEED_MULT[31:0];
    case (state_r)
      S_SEED_M1: begin
        mul_a = seed_q[63:32];
        mul_b = SEED_MULT[31:0];
      end
      S_SEED_M2: begin
        mul_a = seed_q[31:0];
        mul_b = SEED_MULT[63:32];
      end
      default: begin
        mul_a = seed_q[31:0];
        mul_b = SEED_MULT[31:0];
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Generator refill terms
  assign tw_y  = (tw_cur_r & UPPER_MASK) | (gen_rdata_a & LOWER_MASK);
  assign tw_v  = gen_rdata_b ^ (tw_y >> 1) ^ (tw_y[0] ? TWIST_MAG : 64'd0);
  assign gi_p1 = (gi_r == GEN_AW'(MT_N - 1)) ? '0 : gi_r + GEN_AW'(1);
  assign gi_pm = (gi_r >= GEN_AW'(MT_N - MT_M)) ? gi_r - GEN_AW'(MT_N - MT_M)
                                                : gi_r + GEN_AW'(MT_M);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:       if (in_acc && in_data.last_element) state_nxt = S_START;
      S_START:      state_nxt = rank_bad ? S_RESULT : S_ROW_INIT;
      S_ROW_INIT:   if (last_row) state_nxt = S_SEED_FIRST;
      S_SEED_FIRST: state_nxt = S_SEED_M0;
      S_SEED_M0:    state_nxt = S_SEED_M1;
      S_SEED_M1:    state_nxt = S_SEED_M2;
      S_SEED_M2:    state_nxt = S_SEED_WR;
      S_SEED_WR: begin
        state_nxt = (gi_r == GEN_AW'(MT_N - 1)) ? S_ACT_RD : S_SEED_M0;
      end
      S_ACT_RD:     state_nxt = S_ACT_ACC;
      S_ACT_ACC: begin
        if (last_row) begin
          state_nxt = (act_sum == '0) ? S_RESULT : S_GEN_CHK;
        end else begin
          state_nxt = S_ACT_RD;
        end
      end
      S_GEN_CHK: begin
        state_nxt = (gen_idx_r == GEN_AW'(MT_N)) ? S_TW_PRIME : S_GEN_RD;
      end
      S_TW_PRIME:   state_nxt = S_TW_LOAD;
      S_TW_LOAD:    state_nxt = S_TW_RD;
      S_TW_RD:      state_nxt = S_TW_WR;
      S_TW_WR: begin
        state_nxt = (gi_r == GEN_AW'(MT_N - 1)) ? S_GEN_RD : S_TW_RD;
      end
      S_GEN_RD:     state_nxt = S_GEN_TEMPER;
      S_GEN_TEMPER: state_nxt = S_DIV;
      S_DIV:        if (div_cnt_r == '1) state_nxt = S_FIND_RD;
      S_FIND_RD:    state_nxt = S_FIND_CHK;
      S_FIND_CHK: begin
        if (find_hit) begin
          state_nxt = S_PIV_RD;
        end else begin
          state_nxt = last_row ? S_RESULT : S_FIND_RD;
        end
      end
      S_PIV_RD:     state_nxt = S_PIV_GET;
      S_PIV_GET:    state_nxt = S_WALK_RD;
      S_WALK_RD:    state_nxt = S_WALK_ROW;
      S_WALK_ROW:   state_nxt = (c_min >= row_l) ? S_CELL_RD : S_WALK_END;
      S_CELL_RD:    state_nxt = S_CELL_CHK;
      S_CELL_CHK: begin
        state_nxt = (cell_gt && (wc_dec >= wl_r)) ? S_CELL_RD : S_WALK_END;
      end
      S_WALK_END:   state_nxt = last_row ? S_DECIDE : S_WALK_RD;
      S_DECIDE: begin
        if (!strict_r) begin
          state_nxt = (CMP_W'(tot) < CMP_W'(rank_r)) ? S_UPD_RD : S_WALK_RD;
        end else begin
          state_nxt = (CMP_W'(rank_r) <= CMP_W'(tot)) ? S_UPD_RD : S_RESULT;
        end
      end
      S_UPD_RD:     state_nxt = S_UPD_WR;
      S_UPD_WR:     state_nxt = last_row ? S_ITER_NEXT : S_UPD_RD;
      S_ITER_NEXT: begin
        state_nxt = (iter_r == STORE_AW'(STORE_DEPTH - 1)) ? S_RESULT : S_ACT_RD;
      end
      S_RESULT:     if (out_free) state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    size_nxt      = size_r;
    rank_nxt      = rank_r;
    load_pos_nxt  = load_pos_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    cur_n_nxt     = cur_n_r;
    row_idx_nxt   = row_idx_r;
    row_base_nxt  = row_base_r;
    disc_nxt      = disc_r;
    cnt_nxt       = cnt_r;
    base_nxt      = base_r;
    pick_nxt      = pick_r;
    iter_nxt      = iter_r;
    gen_idx_nxt   = gen_idx_r;
    gi_nxt        = gi_r;
    seed_p_nxt    = seed_p_r;
    prod_nxt      = prod_r;
    hi_nxt        = hi_r;
    tw_cur_nxt    = tw_cur_r;
    div_x_nxt     = div_x_r;
    div_cnt_nxt   = div_cnt_r;
    wc_nxt        = wc_r;
    wl_nxt        = wl_r;
    wr_nxt        = wr_r;
    strict_nxt    = strict_r;
    upd_right_nxt = upd_right_r;
    pivot_nxt     = pivot_r;
    found_nxt     = found_r;

    st_we       = in_acc;
    st_raddr    = row_base_r + STORE_AW'($unsigned(wc_r));
    row_we      = 1'b0;
    row_waddr   = row_idx_r;
    row_wdata   = {wl_r, wr_r, wc_r};
    gen_we      = 1'b0;
    gen_waddr   = gi_r;
    gen_wdata   = tw_v;
    gen_raddr_a = gi_p1;
    gen_raddr_b = gi_pm;

    // Configuration writes
    if (cfg_we) begin
      case (cfg_index)
        CFG_MATRIX_SIZE: size_nxt = cfg_wdata[SIZE_W-1:0];
        CFG_RANK:        rank_nxt = cfg_wdata[RANK_W-1:0];
        default:         rank_nxt = rank_r;
      endcase
    end

    // Drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          load_pos_nxt = (load_pos_r == STORE_AW'(STORE_DEPTH - 1)) ? '0
                                                                      : load_pos_r + STORE_AW'(1);
          if (in_data.last_element) begin
            load_pos_nxt = '0;
            if (size_r == '0) begin
              cur_n_nxt = NW'(1);
            end else if (32'(size_r) > MAX_N) begin
              cur_n_nxt = NW'(MAX_N);
            end else begin
              cur_n_nxt = NW'(size_r);
            end
          end
        end
      end
      S_START: begin
        found_nxt   = 1'b0;
        row_idx_nxt = '0;
        disc_nxt    = '0;
      end
      // Open every row to the full column range
      S_ROW_INIT: begin
        row_we      = 1'b1;
        row_wdata   = {CW'(0), n_m1, CW'(0)};
        row_idx_nxt = last_row ? row_idx_r : row_idx_r + RW'(1);
      end
      S_SEED_FIRST: begin
        gen_we     = 1'b1;
        gen_waddr  = '0;
        gen_wdata  = GEN_SEED;
        seed_p_nxt = GEN_SEED;
        gi_nxt     = GEN_AW'(1);
      end
      S_SEED_M0: prod_nxt = mul_p;
      S_SEED_M1: hi_nxt   = mul_p[31:0];
      S_SEED_M2: hi_nxt   = hi_r + mul_p[31:0];
      S_SEED_WR: begin
        gen_we     = 1'b1;
        gen_wdata  = prod_r + {hi_r, 32'd0} + 64'(gi_r);
        seed_p_nxt = prod_r + {hi_r, 32'd0} + 64'(gi_r);
        gi_nxt     = gi_r + GEN_AW'(1);
        if (gi_r == GEN_AW'(MT_N - 1)) begin
          gen_idx_nxt = GEN_AW'(MT_N);
          iter_nxt    = '0;
          row_idx_nxt = '0;
          cnt_nxt     = '0;
        end
      end
      // Sum the active cells over all rows
      S_ACT_ACC: begin
        cnt_nxt     = act_sum;
        row_idx_nxt = last_row ? row_idx_r : row_idx_r + RW'(1);
      end
      S_TW_PRIME: gen_raddr_a = '0;
      S_TW_LOAD: begin
        tw_cur_nxt = gen_rdata_a;
        gi_nxt     = '0;
      end
      // Refill one generator word in place
      S_TW_WR: begin
        gen_we     = 1'b1;
        tw_cur_nxt = gen_rdata_a;
        if (gi_r == GEN_AW'(MT_N - 1)) begin
          gen_idx_nxt = '0;
        end else begin
          gi_nxt = gi_r + GEN_AW'(1);
        end
      end
      S_GEN_RD: begin
        gen_raddr_a = gen_idx_r;
        gen_idx_nxt = gen_idx_r + GEN_AW'(1);
      end
      S_GEN_TEMPER: begin
        div_x_nxt   = gen_temper(gen_rdata_a);
        pick_nxt    = '0;
        div_cnt_nxt = '0;
      end
      S_DIV: begin
        pick_nxt    = div_rem[CNT_W-1:0];
        div_x_nxt   = div_x_r << 1;
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        row_idx_nxt = '0;
        row_base_nxt = '0;
        base_nxt    = '0;
      end
      // Locate the row and column of the picked cell
      S_FIND_CHK: begin
        if (find_hit) begin
          wc_nxt = row_l + CW'(pick_r - base_r);
        end else begin
          base_nxt     = base_r + row_w;
          row_base_nxt = row_base_r + STORE_AW'(cur_n_r);
          row_idx_nxt  = last_row ? row_idx_r : row_idx_r + RW'(1);
        end
      end
      S_PIV_GET: begin
        pivot_nxt    = st_rdata;
        strict_nxt   = 1'b0;
        row_idx_nxt  = '0;
        row_base_nxt = '0;
        cnt_nxt      = '0;
        wc_nxt       = n_m1;
      end
      S_WALK_ROW: begin
        wl_nxt = row_l;
        wr_nxt = row_r;
        wc_nxt = c_min;
      end
      S_CELL_CHK: begin
        if (cell_gt) begin
          wc_nxt = wc_dec;
        end
      end
      // Store the split column and count the cells at or below the pivot (strictly below in the strict pass)
      S_WALK_END: begin
        row_we       = 1'b1;
        cnt_nxt      = cnt_r + walk_add;
        row_idx_nxt  = last_row ? row_idx_r : row_idx_r + RW'(1);
        row_base_nxt = row_base_r + STORE_AW'(cur_n_r);
      end
      S_DECIDE: begin
        row_idx_nxt = '0;
        if (!strict_r) begin
          if (CMP_W'(tot) < CMP_W'(rank_r)) begin
            disc_nxt      = tot;
            upd_right_nxt = 1'b0;
          end else begin
            strict_nxt   = 1'b1;
            row_base_nxt = '0;
            cnt_nxt      = '0;
            wc_nxt       = n_m1;
          end
        end else if (CMP_W'(rank_r) <= CMP_W'(tot)) begin
          upd_right_nxt = 1'b1;
        end else begin
          found_nxt = 1'b1;
        end
      end
      // Narrow the row bounds around the pivot
      S_UPD_WR: begin
        row_we = 1'b1;
        if (!upd_right_r) begin
          row_wdata = {((row_l < row_c + CW'(1)) ? row_c + CW'(1) : row_l), row_r, row_c};
        end else begin
          row_wdata = {row_l, ((row_r > row_c) ? row_c : row_r), row_c};
        end
        row_idx_nxt = last_row ? row_idx_r : row_idx_r + RW'(1);
      end
      S_ITER_NEXT: begin
        iter_nxt    = iter_r + STORE_AW'(1);
        row_idx_nxt = '0;
        cnt_nxt     = '0;
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_item_nxt.found          = found_r;
          out_item_nxt.selected_value = found_r ? pivot_r : 32'sd0;
        end
      end
      default: begin
        found_nxt = found_r;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= SIZE_W'(1);
      rank_r      <= RANK_W'(1);
      load_pos_r  <= '0;
      out_valid_r <= 1'b0;
      gen_idx_r   <= GEN_AW'(MT_N);
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      rank_r      <= rank_nxt;
      load_pos_r  <= load_pos_nxt;
      out_valid_r <= out_valid_nxt;
      gen_idx_r   <= gen_idx_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    cur_n_r     <= cur_n_nxt;
    row_idx_r   <= row_idx_nxt;
    row_base_r  <= row_base_nxt;
    disc_r      <= disc_nxt;
    cnt_r       <= cnt_nxt;
    base_r      <= base_nxt;
    pick_r      <= pick_nxt;
    iter_r      <= iter_nxt;
    gi_r        <= gi_nxt;
    seed_p_r    <= seed_p_nxt;
    prod_r      <= prod_nxt;
    hi_r        <= hi_nxt;
    tw_cur_r    <= tw_cur_nxt;
    div_x_r     <= div_x_nxt;
    div_cnt_r   <= div_cnt_nxt;
    wc_r        <= wc_nxt;
    wl_r        <= wl_nxt;
    wr_r        <= wr_nxt;
    strict_r    <= strict_nxt;
    upd_right_r <= upd_right_nxt;
    pivot_r     <= pivot_nxt;
    found_r     <= found_nxt;
  end

  // Row reads follow the row index in every pass
  logic [RW-1:0] row_raddr;
  assign row_raddr = row_idx_r;

  ksm_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_matrix_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (load_pos_r),
    .wdata (in_data.element_value),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  ksm_ram #(.WIDTH(ROW_DW), .DEPTH(MAX_N)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  // Two copies of the generator state give two reads per cycle
  ksm_ram #(.WIDTH(GEN_W), .DEPTH(MT_N)) u_gen_ram_a (
    .clk   (clk),
    .we    (gen_we),
    .waddr (gen_waddr),
    .wdata (gen_wdata),
    .raddr (gen_raddr_a),
    .rdata (gen_rdata_a)
  );

  ksm_ram #(.WIDTH(GEN_W), .DEPTH(MT_N)) u_gen_ram_b (
    .clk   (clk),
    .we    (gen_we),
    .waddr (gen_waddr),
    .wdata (gen_wdata),
    .raddr (gen_raddr_b),
    .rdata (gen_rdata_b)
  );

  // Assertions
  `KSM_ASSERT_NEXT(a_last_stalls_input, in_valid && in_ready && in_data.last_element,
                   !in_ready, "input not stalled after last element")
  `KSM_ASSERT(a_row_in_range,
              (state_r != S_IDLE && state_r != S_START && state_r != S_RESULT)
                |-> (32'(row_idx_r) < 32'(cur_n_r)), "row index beyond matrix size")
  `KSM_ASSERT(a_gen_index, (gen_idx_r <= GEN_AW'(MT_N)), "generator index out of range")
  `KSM_ASSERT(a_not_found_zero,
              (out_valid_r && !out_item_r.found) |-> (out_item_r.selected_value == 32'sd0),
              "nonzero value without found")

endmodule
